FILE: rtl/mtep_pkg.sv
package mtep_pkg;

    // Per-key note queue sizing.
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // One queue for each channel and key byte: channel * 128 + key.
    localparam int NKEYS       = 2176;
    localparam int KEY_W       = $clog2(NKEYS);
    localparam int PEND_DEPTH  = NKEYS * QUEUE_DEPTH;
    localparam int PEND_AW     = $clog2(PEND_DEPTH);
    localparam int PEND_W      = 39;

    // Chunk epoch tag kept in the bookkeeping word of each key's queue.
    localparam int EPOCH_W     = 4;

    // Result buffer.
    localparam int FIFO_AW     = 3;
    localparam int FIFO_DEPTH  = 1 << FIFO_AW;
    localparam int LEVEL_W     = FIFO_AW + 1;

    // Byte values of the track format.
    localparam logic [7:0] STATUS_BIT  = 8'h80;
    localparam logic [7:0] SYSTEM_BASE = 8'hF0;
    localparam logic [7:0] SYSEX_ESC   = 8'hF7;
    localparam logic [7:0] META_STATUS = 8'hFF;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0] CMD_PROGRAM  = 4'hC;
    localparam logic [3:0] CMD_PRESSURE = 4'hD;

    // Result kinds.
    localparam logic [2:0] KIND_NOTE    = 3'd0;
    localparam logic [2:0] KIND_TEMPO   = 3'd1;
    localparam logic [2:0] KIND_PROGRAM = 3'd2;
    localparam logic [2:0] KIND_DONE    = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Error codes.
    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_BAD_DELTA     = 4'd1;
    localparam logic [3:0] ERR_TIME_OVF      = 4'd2;
    localparam logic [3:0] ERR_ENDS_IN_EVENT = 4'd3;
    localparam logic [3:0] ERR_NO_RUNNING    = 4'd4;
    localparam logic [3:0] ERR_META_TRUNC    = 4'd5;
    localparam logic [3:0] ERR_SYSEX_TRUNC   = 4'd6;
    localparam logic [3:0] ERR_UNSUPPORTED   = 4'd7;
    localparam logic [3:0] ERR_CHAN_TRUNC    = 4'd8;
    localparam logic [3:0] ERR_QUEUE_FULL    = 4'd9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_last;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [30:0] event_tick;
        logic [30:0] note_length;
        logic [7:0]  note_number;
        logic [7:0]  note_velocity;
        logic [23:0] tempo_us_per_quarter;
        logic [7:0]  program_number;
        logic [30:0] track_last_tick;
        logic [3:0]  error_code;
        logic        final_result;
    } result_t;

    // Queue bookkeeping word of one key.
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [QPTR_W-1:0]  head;
        logic [QCNT_W-1:0]  count;
    } queue_meta_t;

    // Up to two results pushed in one cycle.
    typedef struct packed {
        logic [1:0] push_n;
        logic       pop;
    } fifo_ctrl_t;

endpackage

FILE: rtl/midi_track_event_parser.sv
// Track chunk parser for standard MIDI files.
// Bytes enter on the byte channel (byte_valid, byte_stall, byte_item), one byte per
// transfer, with chunk_last marking the final byte of a chunk. Results leave on the
// result channel (result_valid, result_stall, result_item): notes, tempo values, the
// first program change, track done and errors; final_result marks the last result of
// one byte. A byte may cause up to two results.
// Throughput is one byte per cycle while byte_stall is low. Results of a byte reach the
// result channel through stage one, where the note store read supplies start tick and
// velocity, and then the result buffer. The per-key queue bookkeeping is read when
// the key byte arrives and written back when the velocity byte arrives.
// The eight-entry result buffer lets bytes flow while results wait; byte_stall rises
// when fewer than two free entries remain after the results still in flight, so a
// stalled receiver holds input back without losing anything.
// After reset the queue bookkeeping memory is swept, one key per cycle, over all 2176
// keys while byte_stall stays high. Each chunk end starts a new epoch; every
// sixteenth chunk end the epoch tag wraps and the same sweep runs again.
module midi_track_event_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  mtep_pkg::byte_item_t   byte_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output mtep_pkg::result_t      result_item
);
    import mtep_pkg::*;

    localparam logic [3:0] PH_DELTA      = 4'd0;
    localparam logic [3:0] PH_EVENT      = 4'd1;
    localparam logic [3:0] PH_META_TYPE  = 4'd2;
    localparam logic [3:0] PH_META_LEN   = 4'd3;
    localparam logic [3:0] PH_META_DATA  = 4'd4;
    localparam logic [3:0] PH_SYSEX_LEN  = 4'd5;
    localparam logic [3:0] PH_SYSEX_DATA = 4'd6;
    localparam logic [3:0] PH_DATA1      = 4'd7;
    localparam logic [3:0] PH_DATA2      = 4'd8;

    // Parser state.
    logic [3:0]  phase_reg,   phase_next;
    logic [30:0] abs_reg,     abs_next;
    logic [30:0] largest_reg, largest_next;
    logic [7:0]  rs_reg,      rs_next;
    logic [7:0]  evs_reg,     evs_next;
    logic [7:0]  d1_reg,      d1_next;
    logic [27:0] vacc_reg,    vacc_next;
    logic [2:0]  vcnt_reg,    vcnt_next;
    logic [27:0] skip_reg,    skip_next;
    logic [7:0]  mk_reg,      mk_next;
    logic [23:0] tempo_reg,   tempo_next;
    logic        prog_reg,    prog_next;
    logic        stopped_reg, stopped_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;

    // Bookkeeping sweep.
    logic             clear_busy_reg, clear_busy_next;
    logic [KEY_W-1:0] clr_addr_reg,   clr_addr_next;

    // Memories.
    queue_meta_t        meta_mem [NKEYS];
    queue_meta_t        meta_rd_reg;
    logic [PEND_W-1:0]  pend_mem [PEND_DEPTH];
    logic [PEND_W-1:0]  pend_rd_reg;

    logic               meta_re;
    logic [KEY_W-1:0]   meta_raddr;
    logic               note_meta_we;
    queue_meta_t        note_meta_wdata;
    logic               meta_we;
    logic [KEY_W-1:0]   meta_waddr;
    queue_meta_t        meta_wdata;
    logic               pend_we;
    logic               pend_re;
    logic [PEND_AW-1:0] pend_addr;
    logic [PEND_W-1:0]  pend_wdata;

    // Result stage between parser and buffer.
    logic [1:0]  s1_n_reg,    s1_n_next;
    result_t     s1_r0_reg,   s1_r0_next;
    result_t     s1_r1_reg,   s1_r1_next;
    logic        s1_fill_reg, s1_fill_next;
    logic [30:0] s1_tick_reg;

    // Per-byte working signals.
    logic        byte_accept;
    logic [7:0]  b;
    logic        last;
    logic [27:0] acc_base;
    logic [27:0] acc_new;
    logic [2:0]  cnt_inc;
    logic        v_done;
    logic        v_long;
    logic [31:0] tick_sum;
    logic [7:0]  status;
    logic        has_first;
    logic [KEY_W-1:0] key_new;
    logic [KEY_W-1:0] key_cur;
    logic             epoch_match;
    logic [QCNT_W-1:0] q_count;
    logic [QPTR_W-1:0] q_head;
    logic [QCNT_W:0]   pos_sum;
    logic [QPTR_W-1:0] q_tail;
    logic [QPTR_W-1:0] q_head_inc;
    logic        err;
    logic [3:0]  err_code;
    logic        boundary;
    logic        done;
    logic        a_valid;
    result_t     res_a;
    logic        note_fill;
    logic        b_valid;
    result_t     res_b;

    // Finishing the stage-one note.
    logic [30:0] start_tick;
    logic [31:0] diff;
    result_t     fin_r0;
    result_t     fin_r1;

    fifo_ctrl_t         fifo_ctrl;
    logic [LEVEL_W-1:0] fifo_level;
    logic [LEVEL_W:0]   fifo_need;

    assign byte_accept = byte_valid && !byte_stall;
    assign b           = byte_item.data_byte;
    assign last        = byte_item.chunk_last;

    // Keep two free buffer entries beyond what stage one will still push.
    assign fifo_need  = (LEVEL_W+1)'(fifo_level) + (LEVEL_W+1)'(s1_n_reg) + (LEVEL_W+1)'(2);
    assign byte_stall = clear_busy_reg || (fifo_need > (LEVEL_W+1)'(FIFO_DEPTH));

    // Delta and length numbers: seven bits per byte, at most four bytes.
    assign acc_base = (vcnt_reg == 3'd0) ? 28'd0 : vacc_reg;
    assign acc_new  = {acc_base[20:0], b[6:0]};
    assign cnt_inc  = vcnt_reg + 3'd1;
    assign v_done   = !b[7];
    assign v_long   = b[7] && (cnt_inc >= 3'd4);
    assign tick_sum = {1'b0, abs_reg} + {4'b0, acc_new};

    // Queue view of the key named by the current event.
    assign key_cur     = KEY_W'({evs_reg[3:0], 7'b0}) + KEY_W'(d1_reg);
    assign epoch_match = (meta_rd_reg.epoch == epoch_reg);
    assign q_count     = epoch_match ? meta_rd_reg.count : '0;
    assign q_head      = epoch_match ? meta_rd_reg.head : '0;
    assign pos_sum     = (QCNT_W+1)'(q_head) + (QCNT_W+1)'(q_count);
    assign q_tail      = (pos_sum >= (QCNT_W+1)'(QUEUE_DEPTH))
                         ? QPTR_W'(pos_sum - (QCNT_W+1)'(QUEUE_DEPTH))
                         : QPTR_W'(pos_sum);
    assign q_head_inc  = (32'(q_head) == QUEUE_DEPTH - 1) ? '0 : q_head + QPTR_W'(1);

    always_comb
    begin
        phase_next   = phase_reg;
        abs_next     = abs_reg;
        largest_next = largest_reg;
        rs_next      = rs_reg;
        evs_next     = evs_reg;
        d1_next      = d1_reg;
        vacc_next    = vacc_reg;
        vcnt_next    = vcnt_reg;
        skip_next    = skip_reg;
        mk_next      = mk_reg;
        tempo_next   = tempo_reg;
        prog_next    = prog_reg;
        stopped_next = stopped_reg;
        epoch_next   = epoch_reg;

        status    = b;
        has_first = 1'b0;
        key_new   = '0;
        meta_re   = 1'b0;
        meta_raddr = '0;
        note_meta_we    = 1'b0;
        note_meta_wdata = '0;
        pend_we    = 1'b0;
        pend_re    = 1'b0;
        pend_addr  = '0;
        pend_wdata = {abs_reg, b};

        err      = 1'b0;
        err_code = ERR_NONE;
        boundary = 1'b0;
        done     = 1'b0;
        a_valid  = 1'b0;
        res_a    = '0;
        note_fill = 1'b0;
        b_valid  = 1'b0;
        res_b    = '0;

        if (!stopped_reg)
        begin
            unique case (phase_reg)
                PH_DELTA:
                begin
                    vacc_next = acc_new;
                    vcnt_next = cnt_inc;
                    if (v_done)
                    begin
                        vcnt_next = 3'd0;
                        if (tick_sum[31])
                        begin
                            err      = 1'b1;
                            err_code = ERR_TIME_OVF;
                        end
                        else
                        begin
                            abs_next = tick_sum[30:0];
                            if (tick_sum[30:0] > largest_reg)
                            begin
                                largest_next = tick_sum[30:0];
                            end
                            phase_next = PH_EVENT;
                        end
                    end
                    else if (v_long)
                    begin
                        vcnt_next = 3'd0;
                        err       = 1'b1;
                        err_code  = ERR_BAD_DELTA;
                    end
                end
                PH_EVENT:
                begin
                    if (!b[7])
                    begin
                        if (rs_reg == 8'd0)
                        begin
                            err      = 1'b1;
                            err_code = ERR_NO_RUNNING;
                        end
                        status    = rs_reg;
                        has_first = 1'b1;
                    end
                    else
                    begin
                        rs_next = (b < SYSTEM_BASE) ? b : 8'd0;
                    end
                    if (!err)
                    begin
                        evs_next  = status;
                        vcnt_next = 3'd0;
                        if (status == META_STATUS)
                        begin
                            phase_next = PH_META_TYPE;
                        end
                        else if (status == SYSTEM_BASE || status == SYSEX_ESC)
                        begin
                            phase_next = PH_SYSEX_LEN;
                        end
                        else if (status >= SYSTEM_BASE)
                        begin
                            err      = 1'b1;
                            err_code = ERR_UNSUPPORTED;
                        end
                        else if (has_first)
                        begin
                            d1_next = b;
                            if (status[7:4] == CMD_PROGRAM || status[7:4] == CMD_PRESSURE)
                            begin
                                boundary = 1'b1;
                                if (status[7:4] == CMD_PROGRAM && !prog_reg)
                                begin
                                    prog_next = 1'b1;
                                    a_valid   = 1'b1;
                                    res_a.result_kind    = KIND_PROGRAM;
                                    res_a.program_number = b;
                                end
                            end
                            else
                            begin
                                phase_next = PH_DATA2;
                                key_new    = KEY_W'({status[3:0], 7'b0}) + KEY_W'(b);
                                meta_re    = 1'b1;
                                meta_raddr = key_new;
                            end
                        end
                        else
                        begin
                            phase_next = PH_DATA1;
                        end
                    end
                end
                PH_META_TYPE:
                begin
                    mk_next    = b;
                    phase_next = PH_META_LEN;
                end
                PH_META_LEN:
                begin
                    vacc_next = acc_new;
                    vcnt_next = cnt_inc;
                    if (v_done)
                    begin
                        vcnt_next = 3'd0;
                        if (mk_reg == META_TEMPO && acc_new != 28'd3)
                        begin
                            mk_next = 8'd0;
                        end
                        tempo_next = 24'd0;
                        skip_next  = acc_new;
                        if (acc_new == 28'd0)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_META_DATA;
                        end
                    end
                    else if (v_long)
                    begin
                        vcnt_next = 3'd0;
                        err       = 1'b1;
                        err_code  = ERR_META_TRUNC;
                    end
                end
                PH_META_DATA:
                begin
                    if (mk_reg == META_TEMPO)
                    begin
                        tempo_next = {tempo_reg[15:0], b};
                    end
                    skip_next = skip_reg - 28'd1;
                    if (skip_reg == 28'd1)
                    begin
                        done = 1'b1;
                    end
                end
                PH_SYSEX_LEN:
                begin
                    vacc_next = acc_new;
                    vcnt_next = cnt_inc;
                    if (v_done)
                    begin
                        vcnt_next = 3'd0;
                        skip_next = acc_new;
                        if (acc_new == 28'd0)
                        begin
                            boundary = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_SYSEX_DATA;
                        end
                    end
                    else if (v_long)
                    begin
                        vcnt_next = 3'd0;
                        err       = 1'b1;
                        err_code  = ERR_SYSEX_TRUNC;
                    end
                end
                PH_SYSEX_DATA:
                begin
                    skip_next = skip_reg - 28'd1;
                    if (skip_reg == 28'd1)
                    begin
                        boundary = 1'b1;
                    end
                end
                PH_DATA1:
                begin
                    d1_next = b;
                    if (evs_reg[7:4] == CMD_PROGRAM || evs_reg[7:4] == CMD_PRESSURE)
                    begin
                        boundary = 1'b1;
                        if (evs_reg[7:4] == CMD_PROGRAM && !prog_reg)
                        begin
                            prog_next = 1'b1;
                            a_valid   = 1'b1;
                            res_a.result_kind    = KIND_PROGRAM;
                            res_a.program_number = b;
                        end
                    end
                    else
                    begin
                        phase_next = PH_DATA2;
                        key_new    = KEY_W'({evs_reg[3:0], 7'b0}) + KEY_W'(b);
                        meta_re    = 1'b1;
                        meta_raddr = key_new;
                    end
                end
                default:
                begin
                    // Second data byte: note bookkeeping happens here.
                    boundary = 1'b1;
                    if (evs_reg[7:4] == CMD_NOTE_ON && b != 8'd0)
                    begin
                        if (32'(q_count) >= QUEUE_DEPTH)
                        begin
                            err      = 1'b1;
                            err_code = ERR_QUEUE_FULL;
                        end
                        else
                        begin
                            pend_we   = 1'b1;
                            pend_addr = PEND_AW'(32'(key_cur) * QUEUE_DEPTH + 32'(q_tail));
                            note_meta_we          = 1'b1;
                            note_meta_wdata.epoch = epoch_reg;
                            note_meta_wdata.head  = q_head;
                            note_meta_wdata.count = q_count + QCNT_W'(1);
                        end
                    end
                    else if ((evs_reg[7:4] == CMD_NOTE_ON || evs_reg[7:4] == CMD_NOTE_OFF)
                             && q_count != '0)
                    begin
                        pend_re   = 1'b1;
                        pend_addr = PEND_AW'(32'(key_cur) * QUEUE_DEPTH + 32'(q_head));
                        note_meta_we          = 1'b1;
                        note_meta_wdata.epoch = epoch_reg;
                        note_meta_wdata.head  = q_head_inc;
                        note_meta_wdata.count = q_count - QCNT_W'(1);
                        a_valid   = 1'b1;
                        note_fill = 1'b1;
                        res_a.result_kind = KIND_NOTE;
                        res_a.note_number = d1_reg;
                    end
                end
            endcase

            if (done)
            begin
                boundary = 1'b1;
                if (mk_next == META_TEMPO && tempo_next != 24'd0)
                begin
                    a_valid = 1'b1;
                    res_a.result_kind          = KIND_TEMPO;
                    res_a.event_tick           = abs_reg;
                    res_a.tempo_us_per_quarter = tempo_next;
                end
                if (mk_next == META_EOT)
                begin
                    a_valid = 1'b1;
                    res_a.result_kind     = KIND_DONE;
                    res_a.track_last_tick = largest_reg;
                    stopped_next = 1'b1;
                end
            end
            if (boundary && !err)
            begin
                phase_next = PH_DELTA;
            end

            if (!err && !stopped_next && last)
            begin
                if (boundary)
                begin
                    b_valid = 1'b1;
                    res_b.result_kind     = KIND_DONE;
                    res_b.track_last_tick = largest_reg;
                end
                else
                begin
                    err = 1'b1;
                    case (phase_next)
                        PH_DELTA:      err_code = ERR_BAD_DELTA;
                        PH_EVENT:      err_code = ERR_ENDS_IN_EVENT;
                        PH_META_TYPE, PH_META_LEN, PH_META_DATA:
                                       err_code = ERR_META_TRUNC;
                        PH_SYSEX_LEN, PH_SYSEX_DATA:
                                       err_code = ERR_SYSEX_TRUNC;
                        default:       err_code = ERR_CHAN_TRUNC;
                    endcase
                end
            end
            if (err)
            begin
                stopped_next = 1'b1;
            end
        end

        // A chunk end re-arms the parser and opens a new queue epoch.
        if (last)
        begin
            phase_next   = PH_DELTA;
            abs_next     = '0;
            largest_next = '0;
            rs_next      = '0;
            evs_next     = '0;
            d1_next      = '0;
            vacc_next    = '0;
            vcnt_next    = '0;
            skip_next    = '0;
            mk_next      = '0;
            tempo_next   = '0;
            prog_next    = 1'b0;
            stopped_next = 1'b0;
            epoch_next   = epoch_reg + EPOCH_W'(1);
        end
    end

    // Pack the results of this byte for stage one.
    always_comb
    begin
        s1_n_next    = 2'd0;
        s1_r0_next   = res_a;
        s1_r1_next   = res_b;
        s1_fill_next = 1'b0;
        if (err)
        begin
            s1_r0_next = '0;
            s1_r0_next.result_kind  = KIND_ERROR;
            s1_r0_next.error_code   = err_code;
            s1_r0_next.final_result = 1'b1;
            s1_n_next = 2'd1;
        end
        else if (a_valid && b_valid)
        begin
            s1_r1_next.final_result = 1'b1;
            s1_fill_next = note_fill;
            s1_n_next = 2'd2;
        end
        else if (a_valid)
        begin
            s1_r0_next.final_result = 1'b1;
            s1_fill_next = note_fill;
            s1_n_next = 2'd1;
        end
        else if (b_valid)
        begin
            s1_r0_next = res_b;
            s1_r0_next.final_result = 1'b1;
            s1_n_next = 2'd1;
        end
        if (!byte_accept)
        begin
            s1_n_next    = 2'd0;
            s1_fill_next = 1'b0;
        end
    end

    // Sweep control for the queue bookkeeping memory.
    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clr_addr_next   = clr_addr_reg;
        if (clear_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + KEY_W'(1);
            if (32'(clr_addr_reg) == NKEYS - 1)
            begin
                clear_busy_next = 1'b0;
                clr_addr_next   = '0;
            end
        end
        else if (byte_accept && last && epoch_next == '0)
        begin
            clear_busy_next = 1'b1;
        end
    end

    assign meta_we    = clear_busy_reg || (byte_accept && note_meta_we);
    assign meta_waddr = clear_busy_reg ? clr_addr_reg : key_cur;
    assign meta_wdata = clear_busy_reg ? queue_meta_t'('0) : note_meta_wdata;

    always_ff @(posedge clk)
    begin
        if (byte_accept && meta_re)
        begin
            meta_rd_reg <= meta_mem[meta_raddr];
        end
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept && pend_we)
        begin
            pend_mem[pend_addr] <= pend_wdata;
        end
        if (byte_accept && pend_re)
        begin
            pend_rd_reg <= pend_mem[pend_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            s1_r0_reg   <= s1_r0_next;
            s1_r1_reg   <= s1_r1_next;
            s1_tick_reg <= abs_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DELTA;
            abs_reg        <= '0;
            largest_reg    <= '0;
            rs_reg         <= '0;
            evs_reg        <= '0;
            d1_reg         <= '0;
            vacc_reg       <= '0;
            vcnt_reg       <= '0;
            skip_reg       <= '0;
            mk_reg         <= '0;
            tempo_reg      <= '0;
            prog_reg       <= 1'b0;
            stopped_reg    <= 1'b0;
            epoch_reg      <= '0;
            clear_busy_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_n_reg       <= 2'd0;
            s1_fill_reg    <= 1'b0;
        end
        else
        begin
            if (byte_accept)
            begin
                phase_reg   <= phase_next;
                abs_reg     <= abs_next;
                largest_reg <= largest_next;
                rs_reg      <= rs_next;
                evs_reg     <= evs_next;
                d1_reg      <= d1_next;
                vacc_reg    <= vacc_next;
                vcnt_reg    <= vcnt_next;
                skip_reg    <= skip_next;
                mk_reg      <= mk_next;
                tempo_reg   <= tempo_next;
                prog_reg    <= prog_next;
                stopped_reg <= stopped_next;
                epoch_reg   <= epoch_next;
            end
            clear_busy_reg <= clear_busy_next;
            clr_addr_reg   <= clr_addr_next;
            s1_n_reg       <= s1_n_next;
            s1_fill_reg    <= s1_fill_next;
        end
    end

    // Stage one: the note start tick and velocity arrive from the note store.
    assign start_tick = pend_rd_reg[38:8];
    assign diff       = {1'b0, s1_tick_reg} - {1'b0, start_tick};

    always_comb
    begin
        fin_r0 = s1_r0_reg;
        fin_r1 = s1_r1_reg;
        if (s1_fill_reg)
        begin
            fin_r0.event_tick    = start_tick;
            fin_r0.note_velocity = pend_rd_reg[7:0];
            if (diff[31] || diff[30:0] == 31'd0)
            begin
                fin_r0.note_length = 31'd1;
            end
            else
            begin
                fin_r0.note_length = diff[30:0];
            end
        end
    end

    assign fifo_ctrl.push_n = s1_n_reg;
    assign fifo_ctrl.pop    = !result_stall;

    mtep_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fifo_ctrl),
        .push_a    (fin_r0),
        .push_b    (fin_r1),
        .out_valid (result_valid),
        .out_data  (result_item),
        .level     (fifo_level)
    );

    // The sweep owns the bookkeeping memory; no note update may slip in.
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !note_meta_we || !byte_accept)
        else $error("note bookkeeping write during sweep");

    // A chunk end leaves the parser fully re-armed.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_accept && byte_item.chunk_last |=>
            phase_reg == PH_DELTA && !stopped_reg && abs_reg == '0 && largest_reg == '0)
        else $error("parser not re-armed after chunk end");

    // A note fill always targets a note in the first slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fill_reg |-> s1_n_reg != 2'd0 && s1_r0_reg.result_kind == KIND_NOTE)
        else $error("note fill without a note result");

    // The stall margin keeps the result buffer from overflowing.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(fifo_level) + 32'(s1_n_reg) <= FIFO_DEPTH)
        else $error("result buffer overflow");

endmodule

FILE: rtl/mtep_result_fifo.sv
module mtep_result_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mtep_pkg::fifo_ctrl_t        ctrl,
    input  mtep_pkg::result_t           push_a,
    input  mtep_pkg::result_t           push_b,
    output logic                        out_valid,
    output mtep_pkg::result_t           out_data,
    output logic [mtep_pkg::LEVEL_W-1:0] level
);
    import mtep_pkg::*;

    result_t              store [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic [FIFO_AW-1:0]   wr_ptr_b;
    logic                 do_pop;

    assign wr_ptr_b  = wr_ptr_reg + FIFO_AW'(1);
    assign out_valid = (level_reg != '0);
    assign out_data  = store[rd_ptr_reg];
    assign level     = level_reg;
    assign do_pop    = ctrl.pop && out_valid;

    always_ff @(posedge clk)
    begin
        if (ctrl.push_n != 2'd0)
        begin
            store[wr_ptr_reg] <= push_a;
        end
        if (ctrl.push_n == 2'd2)
        begin
            store[wr_ptr_b] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(ctrl.push_n);
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            level_reg <= level_reg + LEVEL_W'(ctrl.push_n) - LEVEL_W'(do_pop);
        end
    end

endmodule
